/* design/iai_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed array insert/erase package
// Item types, operation codes and status codes shared by the array store.
// ----------------------------------------------------------------------------
package iai_pkg;

    typedef struct packed {
        logic        [2:0]  mode;
        logic        [4:0]  position;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_word;
        logic        [4:0]  count;
        logic        [1:0]  status;
    } out_item_t;

    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_ERASE  = 3'd2;
    localparam logic [2:0] MODE_READ   = 3'd3;
    localparam logic [2:0] MODE_WRITE  = 3'd4;
    localparam logic [2:0] MODE_CLEAR  = 3'd5;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

endpackage

/* design/iai_ram.sv */
// ----------------------------------------------------------------------------
// Array store memory
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module iai_ram #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int AW        = 4
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/iai_ctrl.sv */
// ----------------------------------------------------------------------------
// Array store sequencer
// Decodes one item, checks it against the fill count and moves entries
// through the memory one per cycle for insert and erase.
// ----------------------------------------------------------------------------
module iai_ctrl import iai_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int AW        = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output out_item_t            res_item,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [WORD_BITS-1:0] mem_wdata,
    output logic                 mem_re,
    output logic [AW-1:0]        mem_raddr,
    input  logic [WORD_BITS-1:0] mem_rdata
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam int XW   = (WORD_BITS > 32) ? WORD_BITS : 32;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SHIFT_UP = 5'b00010,
        ST_PLACE    = 5'b00100,
        ST_SHIFT_DN = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [1:0]           status_reg, status_next;
    logic                 rd_op_reg, rd_op_next;

    logic [CMPW-1:0]      pos_x;
    logic [CMPW-1:0]      fill_x;
    logic [CW-1:0]        fill_m1;
    logic [AW-1:0]        last_a;
    logic                 full;
    logic signed [XW-1:0] in_x;
    logic [WORD_BITS-1:0] in_word;
    logic signed [XW-1:0] rd_x;

    assign pos_x   = CMPW'(in_item.position);
    assign fill_x  = CMPW'(fill_reg);
    assign fill_m1 = fill_reg - CW'(1);
    assign last_a  = fill_m1[AW-1:0];
    assign full    = (fill_reg == CW'(DEPTH));
    assign in_x    = XW'(in_item.value);
    assign in_word = in_x[WORD_BITS-1:0];
    assign rd_x    = XW'(signed'(mem_rdata));

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        word_next   = word_reg;
        status_next = status_reg;
        rd_op_next  = rd_op_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = word_reg;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        res_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    status_next = STATUS_OK;
                    rd_op_next  = 1'b0;
                    word_next   = in_word;
                    pos_next    = pos_x[AW-1:0];
                    state_next  = ST_FINISH;
                    unique case (in_item.mode)
                        MODE_APPEND: begin
                            if (full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = fill_reg[AW-1:0];
                                mem_wdata = in_word;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        MODE_INSERT: begin
                            if (pos_x > fill_x) begin
                                status_next = STATUS_BAD;
                            end else if (full) begin
                                status_next = STATUS_FULL;
                            end else if (pos_x == fill_x) begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_x[AW-1:0];
                                mem_wdata = in_word;
                                fill_next = fill_reg + CW'(1);
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = last_a;
                                idx_next   = last_a;
                                state_next = ST_SHIFT_UP;
                            end
                        end
                        MODE_ERASE: begin
                            if (pos_x >= fill_x) begin
                                status_next = STATUS_BAD;
                            end else if (pos_x == CMPW'(fill_m1)) begin
                                fill_next = fill_m1;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_x[AW-1:0] + AW'(1);
                                idx_next   = pos_x[AW-1:0] + AW'(1);
                                state_next = ST_SHIFT_DN;
                            end
                        end
                        MODE_READ: begin
                            if (pos_x >= fill_x) begin
                                status_next = STATUS_BAD;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_x[AW-1:0];
                                rd_op_next = 1'b1;
                            end
                        end
                        MODE_WRITE: begin
                            if (pos_x >= fill_x) begin
                                status_next = STATUS_BAD;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_x[AW-1:0];
                                mem_wdata = in_word;
                            end
                        end
                        MODE_CLEAR: begin
                            fill_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + AW'(1);
                mem_wdata = mem_rdata;
                if (idx_reg == pos_reg) begin
                    state_next = ST_PLACE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - AW'(1);
                    idx_next  = idx_reg - AW'(1);
                end
            end
            ST_PLACE: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = word_reg;
                fill_next  = fill_reg + CW'(1);
                state_next = ST_FINISH;
            end
            ST_SHIFT_DN: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = mem_rdata;
                if (idx_reg == last_a) begin
                    fill_next  = fill_m1;
                    state_next = ST_FINISH;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end
            ST_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready           = (state_reg == ST_IDLE);
    assign res_item.read_word = rd_op_reg ? rd_x[31:0] : 32'sd0;
    assign res_item.count     = 5'(fill_reg);
    assign res_item.status    = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        rd_op_reg  <= rd_op_next;
    end

endmodule

/* design/indexed_array_insert_erase.sv */
// ----------------------------------------------------------------------------
// Indexed array insert/erase
// Append, read and write do their work as the item is accepted; the result
// reaches m_item through the finish state and the output register. Clear and
// rejected items do the same. Insert at p moves each entry from p up, then
// writes p; erase at p moves each entry above p down, one entry per cycle.
// Reset clears the fill count and the handshake state; the entries are left.
// ----------------------------------------------------------------------------
module indexed_array_insert_erase import iai_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [4:0] CNT_FULL = 5'(DEPTH);

    logic                 res_valid;
    logic                 res_ready;
    out_item_t            res_item;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg, m_item_next;

    iai_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    iai_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_item_next = res_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_valid)
        else $error("Sequencer offers a result while taking an item.");

    a_word_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.status == STATUS_OK || m_item.read_word == 32'sd0))
        else $error("Non-zero word returned with a failing status.");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == STATUS_FULL) |-> (m_item.count == CNT_FULL))
        else $error("Full status returned while the store is not full.");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> (m_valid && m_item == $past(res_item)))
        else $error("Finished item not loaded into the output register.");

endmodule

/* dv/indexed_array_insert_erase_checker.sv */
// ----------------------------------------------------------------------------
// Indexed array insert/erase checker
// Watches both channels of the array store. Every accepted operation is
// applied to a private copy of the store, and the expected result is queued.
// Each accepted result is compared with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module indexed_array_insert_erase_checker import iai_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        mismatch_count,
    output int        awaited_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 16;
    localparam int REPORT_LIMIT = 10;

    logic signed [31:0] shadow_words [STORE_DEPTH];
    int                 shadow_fill;
    out_item_t          awaited_results [$];
    int                 results_seen;
    int                 errors;

    function automatic out_item_t apply_array_op(in_item_t op);
        out_item_t res;
        int        k;
        res.read_word = '0;
        res.status    = STATUS_OK;
        case (op.mode)
            MODE_APPEND: begin
                if (shadow_fill >= STORE_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    shadow_words[shadow_fill[3:0]] = op.value;
                    shadow_fill = shadow_fill + 1;
                end
            end
            MODE_INSERT: begin
                if (int'(op.position) > shadow_fill) begin
                    res.status = STATUS_BAD;
                end else if (shadow_fill >= STORE_DEPTH) begin
                    res.status = STATUS_FULL;
                end else begin
                    for (k = shadow_fill; k > int'(op.position); k--) begin
                        shadow_words[k[3:0]] = shadow_words[4'(k - 1)];
                    end
                    shadow_words[op.position[3:0]] = op.value;
                    shadow_fill = shadow_fill + 1;
                end
            end
            MODE_ERASE: begin
                if (int'(op.position) >= shadow_fill) begin
                    res.status = STATUS_BAD;
                end else begin
                    for (k = int'(op.position); k + 1 < shadow_fill; k++) begin
                        shadow_words[k[3:0]] = shadow_words[4'(k + 1)];
                    end
                    shadow_fill = shadow_fill - 1;
                end
            end
            MODE_READ: begin
                if (int'(op.position) >= shadow_fill) begin
                    res.status = STATUS_BAD;
                end else begin
                    res.read_word = shadow_words[op.position[3:0]];
                end
            end
            MODE_WRITE: begin
                if (int'(op.position) >= shadow_fill) begin
                    res.status = STATUS_BAD;
                end else begin
                    shadow_words[op.position[3:0]] = op.value;
                end
            end
            MODE_CLEAR: begin
                shadow_fill = 0;
            end
            default: begin
            end
        endcase
        res.count = shadow_fill[4:0];
        return res;
    endfunction

    task automatic flag_result(string what, out_item_t want);
        errors = errors + 1;
        if (errors <= REPORT_LIMIT) begin
            $display("%0t: result %0d %s: expected word %0d count %0d status %0d,",
                     $realtime, results_seen, what, want.read_word, want.count,
                     want.status);
            $display("    got word %0d count %0d status %0d",
                     m_item.read_word, m_item.count, m_item.status);
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    flag_result("arrived with nothing awaited", '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_item.read_word !== want.read_word || m_item.count !== want.count ||
                        m_item.status !== want.status) begin
                        flag_result("differs", want);
                    end
                end
                results_seen = results_seen + 1;
            end
            if (s_valid && s_ready) begin
                awaited_results = {awaited_results, apply_array_op(s_item)};
            end
        end
        mismatch_count <= errors;
        awaited_count  <= awaited_results.size();
    end

endmodule

/* dv/indexed_array_insert_erase_tb.sv */
// ----------------------------------------------------------------------------
// Indexed array insert/erase testbench
// Drives a directed run over the edge cases of the array store, then a long
// run of random operations that fills and drains the store in turn, with
// random gaps on both channels and one long stall of the result channel.
// ----------------------------------------------------------------------------
module indexed_array_insert_erase_tb;
    import iai_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH     = 16;
    localparam int RANDOM_ITEMS    = 1350;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_AT     = 500;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES     = 40;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int mismatch_count;
    int awaited_count;
    int planned_fill  = 0;
    bit send_gapless  = 1'b0;
    bit take_gapless  = 1'b0;
    int results_taken = 0;
    int idle_cycles   = 0;

    always #5 aclk = ~aclk;

    indexed_array_insert_erase i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    indexed_array_insert_erase_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 39))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic offer_op(logic [2:0] mode, logic [4:0] position, logic signed [31:0] value);
        in_item_t op;
        int       gap;
        op.mode     = mode;
        op.position = position;
        op.value    = value;
        gap = send_gapless ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= op;
        do @(posedge aclk); while (!s_ready);
        // The fill level is tracked to aim positions at the valid range and to steer filling and draining.
        case (mode)
            MODE_APPEND: if (planned_fill < STORE_DEPTH) planned_fill++;
            MODE_INSERT: if (position <= planned_fill && planned_fill < STORE_DEPTH) planned_fill++;
            MODE_ERASE:  if (position < planned_fill) planned_fill--;
            MODE_CLEAR:  planned_fill = 0;
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (results_taken % 50 == 0) begin
                take_gapless = ($urandom_range(0, 3) == 0);
            end
            if (results_taken == HOLD_OFF_AT) begin
                gap = HOLD_OFF_CYCLES;
            end else begin
                gap = take_gapless ? 0 : $urandom_range(0, 16);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            results_taken++;
        end
    end

    initial begin
        logic [2:0] mode;
        logic [4:0] position;
        bit         grow;
        int         pick;

        grow = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        offer_op(MODE_READ, 5'd0, '0);
        offer_op(MODE_ERASE, 5'd0, '0);
        offer_op(MODE_WRITE, 5'd0, -32'sd1);
        offer_op(MODE_INSERT, 5'd1, 32'sd5);
        offer_op(MODE_INSERT, 5'd0, WORD_MIN);
        offer_op(MODE_APPEND, 5'd31, WORD_MAX);
        offer_op(MODE_INSERT, 5'd2, -32'sd1);
        offer_op(MODE_INSERT, 5'd1, '0);
        offer_op(MODE_WRITE, 5'd2, 32'sh5555_5555);
        offer_op(MODE_READ, 5'd0, '0);
        offer_op(MODE_READ, 5'd31, -32'sd1);
        offer_op(MODE_ERASE, 5'd1, '0);
        offer_op(MODE_ERASE, 5'd2, '0);
        offer_op(MODE_SPARE_LO, 5'd0, '0);
        offer_op(MODE_SPARE_HI, 5'd31, -32'sd1);
        while (planned_fill < STORE_DEPTH) begin
            offer_op(MODE_APPEND, 5'd0, pick_word());
        end
        offer_op(MODE_APPEND, 5'd0, WORD_MAX);
        offer_op(MODE_INSERT, 5'd16, WORD_MIN);
        offer_op(MODE_INSERT, 5'd17, '0);
        offer_op(MODE_READ, 5'd15, '0);
        offer_op(MODE_ERASE, 5'd0, '0);
        offer_op(MODE_CLEAR, 5'd0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                send_gapless = ($urandom_range(0, 3) == 0);
            end
            if (planned_fill == STORE_DEPTH && $urandom_range(0, 3) == 0) begin
                grow = 1'b0;
            end else if (planned_fill == 0) begin
                grow = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                mode = MODE_CLEAR;
            end else if (pick < 4) begin
                mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
            end else if (pick < (grow ? 30 : 10)) begin
                mode = MODE_APPEND;
            end else if (pick < (grow ? 60 : 25)) begin
                mode = MODE_INSERT;
            end else if (pick < (grow ? 70 : 60)) begin
                mode = MODE_ERASE;
            end else if (pick < 85) begin
                mode = MODE_READ;
            end else begin
                mode = MODE_WRITE;
            end
            if ($urandom_range(0, 99) < 12 || mode == MODE_APPEND || mode == MODE_CLEAR) begin
                position = 5'($urandom_range(0, 31));
            end else if (mode == MODE_INSERT) begin
                position = 5'($urandom_range(0, planned_fill));
            end else begin
                position = (planned_fill == 0) ? 5'd0 : 5'($urandom_range(0, planned_fill - 1));
            end
            offer_op(mode, position, pick_word());
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_count != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && awaited_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
